/* design/sorted_priority_queue_defines.svh */
// Assertion macros for the sorted priority queue design.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge, ignored while reset is high.
`define SPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sorted_priority_queue: assertion failed");

// Checked on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT(label, clk, rst, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* design/spq_pkg.sv */
// Types, codes and constants of the sorted priority queue.
package spq_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int DATA_W           = 32;
   localparam int PRIO_W           = 16;
   localparam int COUNT_OUT_W      = 7;
   localparam int STATUS_W         = 2;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD = 2'b00,
      OP_PUSH = 2'b01,
      OP_POP  = 2'b10
   } spq_op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
   } spq_entry_type;

   typedef struct packed {
      spq_op_type    op;
      spq_entry_type new_entry;
   } spq_cmd_type;

   typedef struct packed {
      logic                     kind;
      logic signed [DATA_W-1:0] item_data;
      logic [PRIO_W-1:0]        item_priority;
   } spq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] front_data;
      logic [PRIO_W-1:0]        front_priority;
      logic                     is_empty;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic [STATUS_W-1:0]      status;
   } spq_rsp_type;

endpackage

/* design/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts it on push or pop.
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  spq_cmd_type   cmd,
   input  logic          is_front,
   input  logic          occupied,
   input  logic          left_after,
   input  spq_entry_type left_entry,
   input  spq_entry_type right_entry,
   output spq_entry_type entry,
   output spq_entry_type entry_nx,
   output logic          after
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // The new word goes behind this slot when this slot sorts ahead of it.
   // The front slot also stays ahead on equal priority.
   always_comb begin
      if (is_front) begin
         after = occupied && (entry_ff.prio <= cmd.new_entry.prio);
      end else begin
         after = occupied && (entry_ff.prio < cmd.new_entry.prio);
      end
   end

   always_comb begin
      unique case (cmd.op)
         OP_PUSH: begin
            if (after) begin
               entry_in = entry_ff;
            end else if (left_after) begin
               entry_in = cmd.new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         OP_POP:  entry_in = right_entry;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign entry_nx = entry_in;

endmodule

/* design/sorted_priority_queue.sv */
// Sorted priority queue: request word in, one response word per request out.
// A request word carries kind (push or pop), item_data and item_priority.
// Entries are kept sorted by ascending priority in a chain of CAPACITY
// slots; a push goes ahead of the first later slot with priority not less
// than its own (the front slot stays ahead on equal priority), and a pop
// removes the front slot. Every request yields one response word with the
// front entry after the operation, is_empty, entry_count and a status.
// A push on a full queue is dropped with status full; a pop on an empty
// queue leaves the queue alone with status empty.
// The response word is registered as the request is taken.
// Throughput is one request per cycle while req_ready is high, since every
// slot compares against the new priority in parallel and shifts in place.
// The response register frees at the same edge it is read, so req_ready
// stays high unless a response waits and rsp_ready is low.
// Reset empties the queue and drops any pending response; slot contents
// are not cleared, as only slots below the count are ever read.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  spq_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_rsp_type rsp_word
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   spq_rsp_type   rsp_word_ff;
   spq_rsp_type   rsp_word_in;

   logic          accept;
   logic          full;
   logic          push_ok;
   logic          pop_ok;
   logic [STATUS_W-1:0] status;
   spq_cmd_type   cmd;

   spq_entry_type cell_entry [CAPACITY];
   spq_entry_type cell_nx    [CAPACITY];
   logic          cell_after [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(CAPACITY));

   always_comb begin
      push_ok = accept && (req_word.kind == KIND_PUSH) && !full;
      pop_ok  = accept && (req_word.kind == KIND_POP) && (count_ff != '0);
      cmd.new_entry.data = req_word.item_data;
      cmd.new_entry.prio = req_word.item_priority;
      if (push_ok) begin
         cmd.op   = OP_PUSH;
         count_in = count_ff + CW'(1);
      end else if (pop_ok) begin
         cmd.op   = OP_POP;
         count_in = count_ff - CW'(1);
      end else begin
         cmd.op   = OP_HOLD;
         count_in = count_ff;
      end
      if (accept && (req_word.kind == KIND_PUSH) && full) begin
         status = STATUS_FULL;
      end else if (accept && (req_word.kind == KIND_POP) && (count_ff == '0)) begin
         status = STATUS_EMPTY;
      end else begin
         status = STATUS_OK;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_entry_type left_entry;
      spq_entry_type right_entry;
      logic          left_after;
      logic          occupied;

      assign occupied = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = cmd.new_entry;
         assign left_after = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_after = cell_after[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .is_front    (i == 0),
         .occupied    (occupied),
         .left_after  (left_after),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .entry_nx    (cell_nx[i]),
         .after       (cell_after[i])
      );
   end

   always_comb begin
      if (count_in == '0) begin
         rsp_word_in.front_data     = '0;
         rsp_word_in.front_priority = '0;
         rsp_word_in.is_empty       = 1'b1;
      end else begin
         rsp_word_in.front_data     = cell_nx[0].data;
         rsp_word_in.front_priority = cell_nx[0].prio;
         rsp_word_in.is_empty       = 1'b0;
      end
      rsp_word_in.entry_count = COUNT_OUT_W'(count_in);
      rsp_word_in.status      = status;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))
   `SPQ_ASSERT(a_push_grows, clock, reset,
      push_ok |=> count_ff == $past(count_ff) + CW'(1))
   `SPQ_ASSERT(a_front_sorted, clock, reset,
      count_ff >= CW'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
   `SPQ_ASSERT(a_full_status, clock, reset,
      rsp_valid_ff && (rsp_word_ff.status == STATUS_FULL) |->
         rsp_word_ff.entry_count == COUNT_OUT_W'(CAPACITY))
   `SPQ_ASSERT(a_empty_zero, clock, reset,
      rsp_valid_ff && rsp_word_ff.is_empty |->
         (rsp_word_ff.front_data == '0) && (rsp_word_ff.front_priority == '0))

endmodule
